/* hw/rtl/s2x_pkg.sv */
// ----------------------------------------------------------------------------
// Scale2x upscaler package
// Shared sizes, register indexes, beat types and the stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package s2x_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int PIXEL_BITS = 32;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS = 10;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [SIZE_BITS-1:0] LINE_WIDTH_RST   = 10'd320;
  localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RST = 10'd200;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        frame_start;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  block_x;
    logic [8:0]  block_y;
    logic [31:0] top_left;
    logic [31:0] top_right;
    logic [31:0] bottom_left;
    logic [31:0] bottom_right;
    logic        last_of_run;
    logic        end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    logic                last_col;
    logic                last_row;
  } pos_t;

  // Everything the block former needs for one source pixel.
  typedef struct packed {
    pos_t pos;
    pix_t pixel;
    pix_t up;
    pix_t m_prev;
    pix_t m_cur;
    pix_t m_next;
    pix_t win0;
    pix_t win1;
  } stage_t;

endpackage

`default_nettype wire

/* hw/rtl/s2x_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module s2x_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/s2x_pos.sv */
// ----------------------------------------------------------------------------
// Scale2x position tracker
// Holds the size registers and the raster position of the next pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module s2x_pos (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [s2x_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [s2x_pkg::SIZE_BITS-1:0]    cfg_data_i,
  input  wire logic                             accept_i,
  input  wire logic                             frame_start_i,
  output s2x_pkg::pos_t                         pos_o
);

  localparam int SB = s2x_pkg::SIZE_BITS;

  logic [SB-1:0] lw_q, fh_q;
  logic [SB-1:0] width, height;
  logic [s2x_pkg::COL_BITS-1:0] col_q, col_d, col;
  logic [s2x_pkg::ROW_BITS-1:0] row_q, row_d, row;
  logic last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= s2x_pkg::LINE_WIDTH_RST;
      fh_q <= s2x_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        s2x_pkg::REG_LINE_WIDTH:   lw_q <= cfg_data_i;
        s2x_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lw_q == '0) begin
      width = SB'(1);
    end else if (lw_q > SB'(s2x_pkg::MAX_WIDTH)) begin
      width = SB'(s2x_pkg::MAX_WIDTH);
    end else begin
      width = lw_q;
    end
    if (fh_q == '0) begin
      height = SB'(1);
    end else if (fh_q > SB'(s2x_pkg::MAX_HEIGHT)) begin
      height = SB'(s2x_pkg::MAX_HEIGHT);
    end else begin
      height = fh_q;
    end
  end

  assign col      = frame_start_i ? '0 : col_q;
  assign row      = frame_start_i ? '0 : row_q;
  assign last_col = ((SB+1)'(col) + (SB+1)'(1)) >= (SB+1)'(width);
  assign last_row = ((SB+1)'(row) + (SB+1)'(1)) >= (SB+1)'(height);

  always_comb begin
    col_d = col + 1'b1;
    row_d = row;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o = '{col: col, row: row, last_col: last_col, last_row: last_row};

endmodule

`default_nettype wire

/* hw/rtl/s2x_emit.sv */
// ----------------------------------------------------------------------------
// Scale2x block former
// Issues the blocks owed for the pixel in the stage into the output register,
// one per cycle while the output register is free or its block is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module s2x_emit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s1_valid_i,
  input  wire s2x_pkg::stage_t    s1_i,
  output logic                    retire_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output s2x_pkg::out_item_t      out_item_o
);

  localparam logic [2:0] BLK_ABOVE = 3'b001;
  localparam logic [2:0] BLK_LEFT  = 3'b010;
  localparam logic [2:0] BLK_LAST  = 3'b100;

  typedef struct packed {
    logic [31:0] tl;
    logic [31:0] tr;
    logic [31:0] bl;
    logic [31:0] br;
  } quad_t;

  function automatic quad_t scale2x(input s2x_pkg::pix_t b, input s2x_pkg::pix_t d,
                                    input s2x_pkg::pix_t e, input s2x_pkg::pix_t f,
                                    input s2x_pkg::pix_t h);
    quad_t q;
    q.tl = 32'((d == b && b != f && d != h) ? d : e);
    q.tr = 32'((b == f && b != d && f != h) ? f : e);
    q.bl = 32'((d == h && d != b && h != f) ? d : e);
    q.br = 32'((h == f && h != d && f != b) ? f : e);
    return q;
  endfunction

  s2x_pkg::pos_t pos;
  logic [2:0] need, sent_q, pending, sel;
  logic last, out_free, move;
  logic out_valid_q;
  s2x_pkg::out_item_t out_q;
  s2x_pkg::pix_t b, d, e, f, h;
  logic [s2x_pkg::COL_BITS-1:0] bx;
  logic [s2x_pkg::ROW_BITS-1:0] by;
  logic eof;
  quad_t q;

  assign pos     = s1_i.pos;
  assign need[0] = pos.row != '0;
  assign need[1] = pos.last_row && pos.col != '0;
  assign need[2] = pos.last_row && pos.last_col;
  assign pending = s1_valid_i ? (need & ~sent_q) : 3'b000;
  assign sel     = pending & (~pending + 3'b001);
  assign last    = (pending & ~sel) == 3'b000;

  assign out_free = !out_valid_q || out_ready_i;
  assign move     = (pending != 3'b000) && out_free;
  assign retire_o = s1_valid_i && ((pending == 3'b000) || (move && last));

  always_comb begin
    e   = s1_i.pixel;
    b   = e;
    d   = e;
    f   = e;
    h   = e;
    bx  = pos.col;
    by  = pos.row;
    eof = 1'b0;
    case (sel)
      BLK_ABOVE: begin
        e  = s1_i.m_cur;
        b  = (pos.row > s2x_pkg::ROW_BITS'(1)) ? s1_i.up : s1_i.m_cur;
        d  = (pos.col != '0) ? s1_i.m_prev : s1_i.m_cur;
        f  = pos.last_col ? s1_i.m_cur : s1_i.m_next;
        h  = s1_i.pixel;
        by = pos.row - 1'b1;
      end
      BLK_LEFT: begin
        e  = s1_i.win0;
        b  = (pos.row != '0) ? s1_i.m_prev : s1_i.win0;
        d  = (pos.col > s2x_pkg::COL_BITS'(1)) ? s1_i.win1 : s1_i.win0;
        f  = s1_i.pixel;
        h  = s1_i.win0;
        bx = pos.col - 1'b1;
      end
      BLK_LAST: begin
        b   = (pos.row != '0) ? s1_i.m_cur : s1_i.pixel;
        d   = (pos.col != '0) ? s1_i.win0 : s1_i.pixel;
        eof = 1'b1;
      end
      default: ;
    endcase
  end

  assign q = scale2x(b, d, e, f, h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (retire_o) begin
        sent_q <= '0;
      end else if (move) begin
        sent_q <= sent_q | sel;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q.block_x      <= 9'(bx);
      out_q.block_y      <= 9'(by);
      out_q.top_left     <= q.tl;
      out_q.top_right    <= q.tr;
      out_q.bottom_left  <= q.bl;
      out_q.bottom_right <= q.br;
      out_q.last_of_run  <= last;
      out_q.end_of_frame <= eof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/scale2x_pixel_upscaler.sv */
// ----------------------------------------------------------------------------
// Scale2x pixel-art upscaler
// Turns a raster stream of source pixels into 2x2 output blocks.
// ----------------------------------------------------------------------------
// Source pixels are taken one per cycle. When a pixel is taken it issues reads
// of the two line memories, and their data arrives in the following cycle.
// The pixel writes its column back when its blocks have been issued; a clash
// between that write and the reads of the following pixel is forwarded. The
// block for a pixel is issued when the pixel below arrives. The first row
// gives no blocks and each pixel of the rows between gives one, so these rows
// run at one pixel per cycle. On the last row each pixel after the first
// gives two blocks and the final pixel three (one and two for a frame of a
// single row). The output register issues one block per cycle, so on that row
// a pixel holds the input until its last block is issued. A block held in
// the output register while the sink is not ready stalls the input. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module scale2x_pixel_upscaler (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire s2x_pkg::in_item_t                in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output s2x_pkg::out_item_t                    out_item_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [s2x_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [s2x_pkg::SIZE_BITS-1:0]    cfg_data_i
);

  localparam int CB = s2x_pkg::COL_BITS;

  logic accept, retire;
  s2x_pkg::pos_t pos;
  logic [CB-1:0] mid_raddr;
  s2x_pkg::pix_t mid_rdata, up_rdata;

  logic s1_valid_q;
  s2x_pkg::pix_t s1_pix_q;
  s2x_pkg::pos_t s1_pos_q;
  logic fwd_mid_q, fwd_up_q;
  s2x_pkg::pix_t fwd_mid_data_q, fwd_up_data_q;
  s2x_pkg::pix_t m_prev_q, m_cur_q, win0_q, win1_q;
  s2x_pkg::pix_t mid_next, up_val;
  s2x_pkg::stage_t s1;

  assign in_ready_o = !s1_valid_q || retire;
  assign accept     = in_valid_i && in_ready_o;

  s2x_pos u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .frame_start_i (in_item_i.frame_start),
    .pos_o         (pos)
  );

  assign mid_raddr = pos.last_col ? '0 : pos.col + 1'b1;

  // Entry c of the middle memory holds the newest pixel of column c and the
  // upper memory the one before it.
  s2x_ram #(
    .WIDTH (s2x_pkg::PIXEL_BITS),
    .DEPTH (s2x_pkg::MAX_WIDTH)
  ) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (retire),
    .waddr_i (s1_pos_q.col),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (mid_raddr),
    .rdata_o (mid_rdata)
  );

  s2x_ram #(
    .WIDTH (s2x_pkg::PIXEL_BITS),
    .DEPTH (s2x_pkg::MAX_WIDTH)
  ) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (retire),
    .waddr_i (s1_pos_q.col),
    .wdata_i (m_cur_q),
    .re_i    (accept),
    .raddr_i (pos.col),
    .rdata_o (up_rdata)
  );

  assign mid_next = fwd_mid_q ? fwd_mid_data_q : mid_rdata;
  assign up_val   = fwd_up_q ? fwd_up_data_q : up_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_mid_q  <= 1'b0;
      fwd_up_q   <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      fwd_mid_q  <= retire && (mid_raddr == s1_pos_q.col);
      fwd_up_q   <= retire && (pos.col == s1_pos_q.col);
    end else if (retire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q       <= s2x_pkg::PIXEL_BITS'(in_item_i.pixel);
      s1_pos_q       <= pos;
      fwd_mid_data_q <= s1_pix_q;
      fwd_up_data_q  <= m_cur_q;
    end
    if (retire) begin
      m_prev_q <= m_cur_q;
      // A one-pixel row has already overwritten column zero itself.
      m_cur_q  <= (s1_pos_q.last_col && s1_pos_q.col == '0) ? s1_pix_q : mid_next;
      win1_q   <= win0_q;
      win0_q   <= s1_pix_q;
    end
  end

  assign s1 = '{
    pos:    s1_pos_q,
    pixel:  s1_pix_q,
    up:     up_val,
    m_prev: m_prev_q,
    m_cur:  m_cur_q,
    m_next: mid_next,
    win0:   win0_q,
    win1:   win1_q
  };

  s2x_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .s1_i        (s1),
    .retire_o    (retire),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* verif/s2x_block_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale2x block checker
// Watches the pixel, block and register ports of the upscaler and keeps its
// own copy of the line stores, window and position. For every pixel beat taken
// it works out the 2x2 blocks due. Each block beat given is then compared,
// field by field, with the oldest block still due.
// ----------------------------------------------------------------------------
module s2x_block_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  s2x_pkg::in_item_t                    in_item_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  s2x_pkg::out_item_t                   out_item_i,
  input  logic                                 cfg_we_i,
  input  logic [s2x_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [s2x_pkg::SIZE_BITS-1:0]        cfg_data_i,
  output int                                   pending_o,
  output int                                   errors_o
);

  import s2x_pkg::*;

  pix_t                 row_a [MAX_WIDTH];
  pix_t                 row_b [MAX_WIDTH];
  pix_t                 win0;
  pix_t                 win1;
  int                   col_q;
  int                   row_q;
  bit                   swap_q;
  logic [SIZE_BITS-1:0] width_reg;
  logic [SIZE_BITS-1:0] height_reg;
  out_item_t            blocks_due [$];
  int                   fault_cnt;

  function automatic int eff_size(input logic [SIZE_BITS-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic pix_t upper_px(input int i);
    return swap_q ? row_b[i] : row_a[i];
  endfunction

  function automatic pix_t middle_px(input int i);
    return swap_q ? row_a[i] : row_b[i];
  endfunction

  function automatic out_item_t form_block(input int x, input int y,
                                           input pix_t b, d, e, f, h, input bit eof);
    out_item_t o;
    o.block_x      = x[8:0];
    o.block_y      = y[8:0];
    o.top_left     = (d == b && b != f && d != h) ? d : e;
    o.top_right    = (b == f && b != d && f != h) ? f : e;
    o.bottom_left  = (d == h && d != b && h != f) ? d : e;
    o.bottom_right = (h == f && h != d && f != b) ? f : e;
    o.last_of_run  = 1'b0;
    o.end_of_frame = eof;
    return o;
  endfunction

  function automatic string show_block(input out_item_t o);
    return $sformatf("x=%0d y=%0d tl=%h tr=%h bl=%h br=%h last=%b eof=%b",
                     o.block_x, o.block_y, o.top_left, o.top_right,
                     o.bottom_left, o.bottom_right, o.last_of_run, o.end_of_frame);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t want;
    out_item_t blk [3];
    pix_t      p;
    pix_t      e;
    pix_t      b;
    pix_t      d;
    pix_t      f;
    int        w;
    int        hgt;
    int        c;
    int        r;
    int        n;
    bit        last_col;
    bit        last_row;
    if (!rst_ni) begin
      foreach (row_a[i]) begin
        row_a[i] = '0;
        row_b[i] = '0;
      end
      win0       = '0;
      win1       = '0;
      col_q      = 0;
      row_q      = 0;
      swap_q     = 1'b0;
      width_reg  = LINE_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      blocks_due.delete();
      fault_cnt  = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_LINE_WIDTH) width_reg = cfg_data_i;
        else if (cfg_index_i == REG_FRAME_HEIGHT) height_reg = cfg_data_i;
      end

      if (out_valid_i && out_ready_i) begin
        if (blocks_due.size() == 0) begin
          if (fault_cnt < 10) $display("Unexpected block beat: %s", show_block(out_item_i));
          fault_cnt++;
        end else begin
          want = blocks_due.pop_front();
          if (out_item_i.block_x      !== want.block_x      ||
              out_item_i.block_y      !== want.block_y      ||
              out_item_i.top_left     !== want.top_left     ||
              out_item_i.top_right    !== want.top_right    ||
              out_item_i.bottom_left  !== want.bottom_left  ||
              out_item_i.bottom_right !== want.bottom_right ||
              out_item_i.last_of_run  !== want.last_of_run  ||
              out_item_i.end_of_frame !== want.end_of_frame) begin
            if (fault_cnt < 10) begin
              $display("Block beat mismatch at %0t", $realtime);
              $display("  expected %s", show_block(want));
              $display("  actual   %s", show_block(out_item_i));
            end
            fault_cnt++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        p   = in_item_i.pixel;
        w   = eff_size(width_reg, MAX_WIDTH);
        hgt = eff_size(height_reg, MAX_HEIGHT);
        n   = 0;
        if (in_item_i.frame_start) begin
          col_q = 0;
          row_q = 0;
        end
        c = col_q;
        r = row_q;
        if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= hgt);

        if (r > 0) begin
          e = middle_px(c);
          b = (r > 1) ? upper_px(c) : e;
          d = (c > 0) ? middle_px(c - 1) : e;
          f = last_col ? e : middle_px(c + 1);
          blk[n] = form_block(c, r - 1, b, d, e, f, p, 1'b0);
          n++;
        end
        if (last_row) begin
          if (c > 0) begin
            e = win0;
            b = (r > 0) ? middle_px(c - 1) : e;
            d = (c > 1) ? win1 : e;
            blk[n] = form_block(c - 1, r, b, d, e, p, e, 1'b0);
            n++;
          end
          if (last_col) begin
            b = (r > 0) ? middle_px(c) : p;
            d = (c > 0) ? win0 : p;
            blk[n] = form_block(c, r, b, d, p, p, p, 1'b1);
            n++;
          end
        end
        if (n > 0) blk[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++) blocks_due.push_back(blk[k]);

        if (swap_q) row_b[c] = p;
        else row_a[c] = p;
        win1 = win0;
        win0 = p;
        if (last_col) begin
          col_q  = 0;
          swap_q = !swap_q;
          row_q  = last_row ? 0 : r + 1;
        end else begin
          col_q = c + 1;
        end
      end

      pending_o <= blocks_due.size();
      errors_o  <= fault_cnt;
    end
  end

endmodule

/* verif/tb_scale2x_pixel_upscaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale2x upscaler testbench
// Drives raster pixel streams through the upscaler under a range of row and
// frame sizes, including out-of-range and mid-frame reduced sizes, with
// random idling on both channels. A separate checker predicts and compares
// every block beat; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_scale2x_pixel_upscaler;

  import s2x_pkg::*;

  logic                    clk_i;
  logic                    rst_ni    = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  in_item_t                in_item   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_item;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_LINE_WIDTH;
  logic [SIZE_BITS-1:0]    cfg_data  = '0;
  int                      pending;
  int                      errors;
  bit                      quiet     = 1'b0;
  int                      n_sent    = 0;
  pix_t                    palette [3];
  pix_t                    fixed_px [$];

  scale2x_pixel_upscaler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  s2x_block_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready <= quiet || ($urandom_range(99) >= 16);
  end

  function automatic pix_t pick_pixel();
    if (fixed_px.size() != 0) return fixed_px.pop_front();
    if ($urandom_range(3) != 0) return palette[$urandom_range(2)];
    return $urandom;
  endfunction

  task automatic send_pixel(input in_item_t it);
    while (!quiet && ($urandom_range(99) < 16)) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_sizes(input logic [SIZE_BITS-1:0] lw, input logic [SIZE_BITS-1:0] fh);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_WIDTH;
    cfg_data  <= lw;
    @(posedge clk_i);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= fh;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [SIZE_BITS-1:0] lw, input logic [SIZE_BITS-1:0] fh,
                           input int count, input bit restart, input int restart_pct);
    in_item_t it;
    drain(16);
    write_sizes(lw, fh);
    for (int i = 0; i < count; i++) begin
      it.pixel       = pick_pixel();
      it.frame_start = (i == 0) ? restart : ($urandom_range(99) < restart_pct);
      send_pixel(it);
      if (($urandom_range(99) < 3) || (n_sent == 100)) drain(0);
    end
  endtask

  initial begin : stimulus
    logic [SIZE_BITS-1:0] lw;
    logic [SIZE_BITS-1:0] fh;
    int                   frame_px;
    int                   kind;
    int                   rnd_start;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Centre pixel with equal left/above and equal right/below neighbours.
    fixed_px = '{32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h5A5A_5A5A,
                 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000,
                 32'h0F0F_0F0F, 32'h0000_0000, 32'hF0F0_F0F0};
    run_phase(3, 3, 9, 1'b1, 0);
    // Centre pixel with equal above/right and equal left/below neighbours.
    fixed_px = '{32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h5A5A_5A5A,
                 32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF,
                 32'h0F0F_0F0F, 32'h0000_0000, 32'hF0F0_F0F0};
    run_phase(3, 3, 9, 1'b1, 0);
    fixed_px = '{32'h0000_0000, 32'hFFFF_FFFF};
    run_phase(0, 0, 2, 1'b1, 0);
    fixed_px = '{32'hFFFF_FFFF, 32'h0000_0000};
    run_phase(2, 1, 2, 1'b1, 0);
    fixed_px = '{32'h0000_0000, 32'hFFFF_FFFF};
    run_phase(1, 2, 2, 1'b1, 0);

    palette[0] = 32'h0000_0000;
    palette[1] = 32'hFFFF_FFFF;
    palette[2] = $urandom;
    // Maximum and oversized rows and frames, each cut short by a smaller size mid-frame.
    quiet <= 1'b1;
    run_phase(1023, 2, 41, 1'b1, 0);
    run_phase(5, 2, 6, 1'b0, 0);
    quiet <= 1'b0;
    run_phase(1, 512, 20, 1'b1, 0);
    run_phase(1, 3, 4, 1'b0, 0);
    run_phase(512, 1, 6, 1'b1, 0);
    run_phase(3, 1, 3, 1'b0, 0);
    run_phase(2, 1023, 6, 1'b1, 0);
    run_phase(2, 2, 4, 1'b0, 0);

    rnd_start = n_sent;
    while (n_sent - rnd_start < 30) begin
      for (int k = 0; k < 3; k++) begin
        palette[k] = ($urandom_range(3) == 0) ? {32{$urandom_range(1) == 1}} : $urandom;
      end
      kind = $urandom_range(9);
      lw   = $urandom_range(1, 7);
      fh   = $urandom_range(1, 5);
      if ($urandom_range(9) == 0) lw = 0;
      if ($urandom_range(9) == 0) fh = 0;
      frame_px = ((lw == 0) ? 1 : lw) * ((fh == 0) ? 1 : fh);
      if (kind < 7) run_phase(lw, fh, frame_px * $urandom_range(1, 2), 1'b1, 2);
      else if (kind < 9) run_phase(lw, fh, $urandom_range(1, frame_px + 3), 1'b1, 0);
      else run_phase(lw, fh, frame_px * 2, 1'b1, 25);
    end

    drain(20);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
